[hdl/cmm_pkg.sv]
// Package for the column-major matrix multiply unit.
// Types, opcodes and size constants used by every file but cmm_if; no dependencies.
`default_nettype none
package cmm_pkg;
    localparam int MAX_DIM_DEF   = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_W         = 6;
    localparam int IDX_W         = 5;
    localparam int VAL_W         = 32;

    typedef enum logic [1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        REG_ROWS_A    = 2'd0,
        REG_INNER_LEN = 2'd1,
        REG_COLS_B    = 2'd2,
        REG_NONE      = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MAC  = 2'd1,
        ST_OUT  = 2'd2
    } t_state;

    // command handed from front to back
    typedef struct packed {
        logic             bad;
        logic [IDX_W-1:0] col;
        logic [CFG_W-1:0] nr;
        logic [CFG_W-1:0] nk;
    } t_cmd;

    // effective size: clamp register into 1 .. cap
    function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] cap);
        logic [CFG_W-1:0] r;
        begin
            r = v;
            if (v == '0) r = 6'd1;
            else if (v > cap) r = cap;
            return r;
        end
    endfunction
endpackage
`default_nettype wire

[hdl/cmm_if.sv]
// Valid/ready channel carrying one word of payload type T.
// Depends on nothing; used with types from cmm_pkg.
`default_nettype none
interface cmm_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/cmm_front.sv]
// Front end: accepts words, writes element stores, queues compute commands.
// Depends on cmm_pkg.
`default_nettype none
module cmm_front #(
    parameter int MAX_DIM = 32,
    parameter int AW      = 10
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [1:0]                i_opcode,
    input  wire logic [4:0]                i_row,
    input  wire logic [4:0]                i_col,
    input  wire logic [31:0]               i_val,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [5:0]                i_nr,
    input  wire logic [5:0]                i_nk,
    input  wire logic [5:0]                i_nc,
    input  wire logic                      i_back_idle,
    output logic                           o_a_we,
    output logic                           o_b_we,
    output logic [AW-1:0]                  o_waddr,
    output logic [31:0]                    o_wdata,
    output cmm_pkg::t_cmd                  o_cmd,
    output logic                           o_cmd_valid,
    input  wire logic                      i_cmd_pop
);
    import cmm_pkg::*;
    localparam int RW = $clog2(MAX_DIM);

    // two-entry command queue
    t_cmd       r_q [2];
    logic [1:0] r_cnt;
    logic       r_wp, r_rp;
    logic       acc, push, is_a, is_b, wr_op;

    // hold element writes until every queued column has been computed
    assign wr_op   = (t_opcode'(i_opcode) == OP_WRITE_A)
                     || (t_opcode'(i_opcode) == OP_WRITE_B);
    assign o_ready = (r_cnt != 2'd2) && (!wr_op || ((r_cnt == 2'd0) && i_back_idle));
    assign acc     = i_valid && o_ready;
    assign is_a    = acc && (t_opcode'(i_opcode) == OP_WRITE_A)
                     && ({1'b0, i_row} < i_nr) && ({1'b0, i_col} < i_nk);
    assign is_b    = acc && (t_opcode'(i_opcode) == OP_WRITE_B)
                     && ({1'b0, i_row} < i_nk) && ({1'b0, i_col} < i_nc);
    assign push    = acc && (t_opcode'(i_opcode) == OP_COMPUTE);

    assign o_a_we  = is_a;
    assign o_b_we  = is_b;
    assign o_waddr = {RW'(i_col), RW'(i_row)};
    assign o_wdata = i_val;
    assign o_cmd   = r_q[r_rp];
    assign o_cmd_valid = (r_cnt != 2'd0);

    // hold queued commands
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp].bad <= ({1'b0, i_col} >= i_nc);
            r_q[r_wp].col <= i_col;
            r_q[r_wp].nr  <= i_nr;
            r_q[r_wp].nk  <= i_nk;
        end
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_cmd_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_cmd_pop};
        end
    end

    ap_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> o_cmd_valid) else $error("pop of empty queue");
    ap_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    ap_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !o_ready) else $error("accept while full");
endmodule
`default_nettype wire

[hdl/cmm_back.sv]
// Back end: element memories, serial multiply-accumulate, result register.
// Depends on cmm_pkg.
`default_nettype none
module cmm_back #(
    parameter int MAX_DIM   = 32,
    parameter int FRAC_BITS = 16,
    parameter int AW        = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_a_we,
    input  wire logic          i_b_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [31:0]   i_wdata,
    input  cmm_pkg::t_cmd      i_cmd,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_pop,
    output logic               o_idle,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [31:0]        o_value,
    output logic [4:0]         o_row,
    output logic [4:0]         o_col,
    output logic               o_last,
    output logic               o_sat,
    output logic               o_bad
);
    import cmm_pkg::*;
    localparam int RW    = $clog2(MAX_DIM);
    localparam int DEPTH = 1 << AW;
    localparam int ACC_W = 64 + 6;

    logic [31:0] r_amem [DEPTH];
    logic [31:0] r_bmem [DEPTH];
    logic [31:0] r_ad, r_bd;

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [5:0] r_r, r_k;        // row and inner counters
    logic       r_rd_v, r_mul_v; // pipeline valids
    logic       r_rd_lst, r_mul_lst;
    logic signed [63:0]    r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic       r_acc_done;
    logic       issue, take, out_free, emit_word;

    // memories: one write and one read port each
    always_ff @(posedge i_clk) begin
        if (i_a_we) r_amem[i_waddr] <= i_wdata;
        if (i_b_we) r_bmem[i_waddr] <= i_wdata;
        r_ad <= r_amem[{RW'(r_k), RW'(r_r)}];
        r_bd <= r_bmem[{RW'(r_cmd.col), RW'(r_k)}];
    end

    assign out_free  = !o_valid || i_ready;
    assign issue     = (r_state == ST_MAC);
    assign take      = (r_state == ST_IDLE) && i_cmd_valid;
    assign emit_word = (r_state == ST_OUT) && (r_cmd.bad || r_acc_done) && out_free;
    assign o_idle    = (r_state == ST_IDLE);

    // next state
    always_comb begin
        n_state   = r_state;
        o_cmd_pop = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_state   = i_cmd.bad ? ST_OUT : ST_MAC;
                end
            end
            ST_MAC: begin
                if (r_k + 6'd1 == r_cmd.nk) n_state = ST_OUT;
            end
            ST_OUT: begin
                if ((r_cmd.bad || r_acc_done) && out_free) begin
                    if (r_cmd.bad || (r_r + 6'd1 == r_cmd.nr)) n_state = ST_IDLE;
                    else n_state = ST_MAC;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // shifted sum and saturation
    logic signed [ACC_W-1:0] sh;
    logic       sat_hi, sat_lo;
    assign sh     = r_acc >>> FRAC_BITS;
    assign sat_hi = sh > $signed({{(ACC_W-32){1'b0}}, 32'h7FFF_FFFF});
    assign sat_lo = sh < $signed({{(ACC_W-32){1'b1}}, 32'h8000_0000});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_rd_v     <= 1'b0;
            r_mul_v    <= 1'b0;
            r_acc_done <= 1'b0;
            o_valid    <= 1'b0;
            r_r        <= '0;
            r_k        <= '0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= issue;
            r_rd_lst <= issue && (r_k + 6'd1 == r_cmd.nk);
            r_mul_v <= r_rd_v;
            r_mul_lst <= r_rd_lst;
            if (emit_word) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
            if (take) begin
                r_cmd <= i_cmd;
                r_r   <= '0;
                r_k   <= '0;
                r_acc <= '0;
                r_acc_done <= 1'b0;
            end
            if (issue) r_k <= r_k + 6'd1;
            if (r_mul_v) begin
                r_acc <= r_acc + {{(ACC_W-64){r_prod[63]}}, r_prod};
                if (r_mul_lst) r_acc_done <= 1'b1;
            end
            // drive one result word
            if (emit_word) begin
                o_col   <= r_cmd.col;
                o_bad   <= r_cmd.bad;
                if (r_cmd.bad) begin
                    o_value <= '0;
                    o_row   <= '0;
                    o_last  <= 1'b1;
                    o_sat   <= 1'b0;
                end else begin
                    o_row   <= r_r[4:0];
                    o_last  <= (r_r + 6'd1 == r_cmd.nr);
                    o_sat   <= sat_hi || sat_lo;
                    o_value <= sat_hi ? 32'h7FFF_FFFF :
                               sat_lo ? 32'h8000_0000 : sh[31:0];
                    r_r     <= r_r + 6'd1;
                    r_k     <= '0;
                    r_acc   <= '0;
                    r_acc_done <= 1'b0;
                end
            end
        end
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        r_prod <= $signed(r_ad) * $signed(r_bd);
    end

    ap_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == ST_IDLE)) else $error("pop while busy");
    ap_mac_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC) |-> (r_k < r_cmd.nk)) else $error("inner index overrun");
    ap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_value)))
        else $error("result dropped");
endmodule
`default_nettype wire

[hdl/column_major_matrix_multiply_unit.sv]
// Top level of the column-major matrix multiply unit.
// Depends on cmm_pkg, cmm_if, cmm_front and cmm_back.
// A compute word leaves the command queue when the back end is idle, then
// yields one result per row of A (rows_a after clamping), or a single result
// for a bad column. Each result comes from the single shared multiplier and
// its read/multiply/accumulate pipeline, one row after another, and waits
// while the output is stalled. A two-entry command queue lets compute words
// queue up; a load word waits until the queue is empty and the back end is
// idle, so it never changes a column in progress.
`default_nettype none
module column_major_matrix_multiply_unit #(
    parameter int MAX_DIM   = cmm_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = cmm_pkg::FRAC_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [5:0] i_cfg_data,
    cmm_if.sink             s_in,
    cmm_if.source           m_out
);
    import cmm_pkg::*;
    localparam int AW  = 2 * $clog2(MAX_DIM);
    localparam logic [5:0] CAP = (MAX_DIM < 32) ? 6'(MAX_DIM) : 6'd32;

    logic [5:0] r_rows_a, r_inner_len, r_cols_b;
    logic [5:0] nr, nk, nc;

    // hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= 6'd32;
            r_inner_len <= 6'd32;
            r_cols_b    <= 6'd32;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_ROWS_A:    r_rows_a    <= i_cfg_data;
                REG_INNER_LEN: r_inner_len <= i_cfg_data;
                REG_COLS_B:    r_cols_b    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign nr = eff_size(r_rows_a, CAP);
    assign nk = eff_size(r_inner_len, CAP);
    assign nc = eff_size(r_cols_b, CAP);

    logic a_we, b_we, cmd_valid, cmd_pop, back_idle;
    logic [AW-1:0] waddr;
    logic [31:0] wdata;
    t_cmd cmd;

    cmm_front #(.MAX_DIM(MAX_DIM), .AW(AW)) u_front (
        .i_clk, .i_rst_n,
        .i_opcode(s_in.data.opcode), .i_row(s_in.data.row_index),
        .i_col(s_in.data.col_index), .i_val(s_in.data.elem_value),
        .i_valid(s_in.valid), .o_ready(s_in.ready),
        .i_nr(nr), .i_nk(nk), .i_nc(nc), .i_back_idle(back_idle),
        .o_a_we(a_we), .o_b_we(b_we), .o_waddr(waddr), .o_wdata(wdata),
        .o_cmd(cmd), .o_cmd_valid(cmd_valid), .i_cmd_pop(cmd_pop)
    );

    cmm_back #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS), .AW(AW)) u_back (
        .i_clk, .i_rst_n,
        .i_a_we(a_we), .i_b_we(b_we), .i_waddr(waddr), .i_wdata(wdata),
        .i_cmd(cmd), .i_cmd_valid(cmd_valid), .o_cmd_pop(cmd_pop),
        .o_idle(back_idle),
        .o_valid(m_out.valid), .i_ready(m_out.ready),
        .o_value(m_out.data.result_value), .o_row(m_out.data.result_row),
        .o_col(m_out.data.result_col), .o_last(m_out.data.last),
        .o_sat(m_out.data.saturated), .o_bad(m_out.data.bad_column)
    );
endmodule
`default_nettype wire

[tb/column_major_matrix_multiply_unit_tb.sv]
// Testbench for the column-major matrix multiply unit: loads A and B, computes columns,
// and checks every result word against an in-bench predictor of the dot products.
// Depends on cmm_pkg, cmm_if and column_major_matrix_multiply_unit.
`timescale 1ns / 100ps
`default_nettype none
module column_major_matrix_multiply_unit_tb;
    import cmm_pkg::*;

    localparam int  DIM       = 32;
    localparam int  FRAC      = 16;
    localparam int  DRAIN_CYC = 60;
    localparam longint CYCLE_LIMIT = 1_500_000;
    localparam logic signed [95:0] Q_MAX = 96'sh7FFF_FFFF;
    localparam logic signed [95:0] Q_MIN = -96'sh8000_0000;

    typedef struct packed {
        t_opcode            opcode;
        logic [IDX_W-1:0]   row_index;
        logic [IDX_W-1:0]   col_index;
        logic signed [31:0] elem_value;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [IDX_W-1:0]   result_row;
        logic [IDX_W-1:0]   result_col;
        logic               last;
        logic               saturated;
        logic               bad_column;
    } t_out_word;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [5:0] i_cfg_data;

    cmm_if #(.T(t_in_word))  in_ch ();
    cmm_if #(.T(t_out_word)) out_ch ();

    column_major_matrix_multiply_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (in_ch.sink),
        .m_out      (out_ch.source)
    );

    // predictor state
    logic [31:0] a_elems [0:DIM*DIM-1];
    logic [31:0] b_elems [0:DIM*DIM-1];
    bit          a_loaded [0:DIM*DIM-1];
    bit          b_loaded [0:DIM*DIM-1];
    logic [5:0]  rows_reg, inner_reg, cols_reg;
    t_out_word   pending_results [$];

    int  fail_count;
    int  words_sent;
    int  results_seen;
    int  compute_words;
    int  sat_seen;
    int  burst_left;
    int  hold_cycles;
    longint cycle_count;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int eff_dim(input logic [5:0] v);
        if (v == 6'd0) return 1;
        if (v > 6'd32) return DIM;
        return int'(v);
    endfunction

    // predict the result words of one accepted input word
    task automatic predict_word(input t_in_word w);
        int nr, nk, nc, r, k;
        logic signed [31:0] av, bv;
        logic signed [63:0] prod;
        logic signed [95:0] acc, shifted;
        t_out_word res;
        begin
            nr = eff_dim(rows_reg);
            nk = eff_dim(inner_reg);
            nc = eff_dim(cols_reg);
            case (w.opcode)
                OP_WRITE_A: begin
                    if (w.row_index < nr && w.col_index < nk) begin
                        a_elems[w.col_index*DIM + w.row_index] = w.elem_value;
                        a_loaded[w.col_index*DIM + w.row_index] = 1'b1;
                    end
                end
                OP_WRITE_B: begin
                    if (w.row_index < nk && w.col_index < nc) begin
                        b_elems[w.col_index*DIM + w.row_index] = w.elem_value;
                        b_loaded[w.col_index*DIM + w.row_index] = 1'b1;
                    end
                end
                OP_COMPUTE: begin
                    compute_words++;
                    if (w.col_index >= nc) begin
                        res = '0;
                        res.result_col = w.col_index;
                        res.last = 1'b1;
                        res.bad_column = 1'b1;
                        pending_results.push_back(res);
                    end else begin
                        for (r = 0; r < nr; r++) begin
                            acc = '0;
                            for (k = 0; k < nk; k++) begin
                                av = a_elems[k*DIM + r];
                                bv = b_elems[w.col_index*DIM + k];
                                prod = av * bv;
                                acc = acc + prod;
                            end
                            shifted = acc >>> FRAC;
                            res = '0;
                            res.result_row = r[4:0];
                            res.result_col = w.col_index;
                            res.last = (r == nr - 1);
                            if (shifted > Q_MAX) begin
                                res.result_value = 32'sh7FFF_FFFF;
                                res.saturated = 1'b1;
                            end else if (shifted < Q_MIN) begin
                                res.result_value = 32'sh8000_0000;
                                res.saturated = 1'b1;
                            end else begin
                                res.result_value = shifted[31:0];
                            end
                            pending_results.push_back(res);
                        end
                    end
                end
                default: ;
            endcase
        end
    endtask

    // send one word, with bursts and random gaps
    task automatic send_word(input t_in_word w);
        int gap;
        begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    @(negedge i_clk);
                    in_ch.valid <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
            burst_left--;
            @(negedge i_clk);
            in_ch.valid <= 1'b1;
            in_ch.data  <= w;
            forever begin
                @(posedge i_clk);
                if (in_ch.ready) break;
            end
            predict_word(w);
            words_sent++;
        end
    endtask

    task automatic send_op(input t_opcode op, input int row, input int col,
                           input logic [31:0] val);
        t_in_word w;
        begin
            w.opcode = op;
            w.row_index = row[4:0];
            w.col_index = col[4:0];
            w.elem_value = val;
            send_word(w);
        end
    endtask

    // drop valid, wait for all results, then let the pipeline settle
    task automatic drain_all();
        begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            while (pending_results.size() != 0) @(posedge i_clk);
            repeat (DRAIN_CYC) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [5:0] v);
        begin
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= v;
            @(posedge i_clk);
            case (idx)
                REG_ROWS_A:    rows_reg = v;
                REG_INNER_LEN: inner_reg = v;
                REG_COLS_B:    cols_reg = v;
                default: ;
            endcase
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
        end
    endtask

    task automatic set_sizes(input logic [5:0] nr, input logic [5:0] nk, input logic [5:0] nc);
        begin
            drain_all();
            write_reg(REG_ROWS_A, nr);
            write_reg(REG_INNER_LEN, nk);
            write_reg(REG_COLS_B, nc);
        end
    endtask

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h4_0000);
            3: return -$urandom_range(0, 32'h4_0000);
            default: return $urandom;
        endcase
    endfunction

    // write every element that the current sizes read and that was never loaded;
    // a non-negative only_col limits B to that one column
    task automatic fill_missing(input int only_col);
        int nr, nk, nc, r, k, c;
        begin
            nr = eff_dim(rows_reg);
            nk = eff_dim(inner_reg);
            nc = eff_dim(cols_reg);
            for (k = 0; k < nk; k++)
                for (r = 0; r < nr; r++)
                    if (!a_loaded[k*DIM + r]) send_op(OP_WRITE_A, r, k, rand_elem());
            for (c = 0; c < nc; c++)
                if (only_col < 0 || c == only_col)
                    for (k = 0; k < nk; k++)
                        if (!b_loaded[c*DIM + k]) send_op(OP_WRITE_B, k, c, rand_elem());
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_word got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            results_seen++;
            if (got.saturated) sat_seen++;
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: row %0d col %0d",
                       got.result_row, got.result_col);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.result_value !== want.result_value) begin
                    $error("result_value: expected %h, got %h", want.result_value,
                           got.result_value);
                    fail_count++;
                end
                if (got.result_row !== want.result_row) begin
                    $error("result_row: expected %0d, got %0d", want.result_row,
                           got.result_row);
                    fail_count++;
                end
                if (got.result_col !== want.result_col) begin
                    $error("result_col: expected %0d, got %0d", want.result_col,
                           got.result_col);
                    fail_count++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, got.last);
                    fail_count++;
                end
                if (got.saturated !== want.saturated) begin
                    $error("saturated: expected %b, got %b", want.saturated, got.saturated);
                    fail_count++;
                end
                if (got.bad_column !== want.bad_column) begin
                    $error("bad_column: expected %b, got %b", want.bad_column,
                           got.bad_column);
                    fail_count++;
                end
            end
        end
    end

    // receiver: long hold-off on request, otherwise free stretches and random stalls
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end else if ((cycle_count % 80) < 24) begin
            out_ch.ready <= 1'b1;
        end else begin
            out_ch.ready <= ($urandom_range(0, 2) != 0);
        end
    end

    // saturation, exact minimum, bad columns, ignored words
    task automatic test_corner_values();
        begin
            set_sizes(6'd2, 6'd2, 6'd2);
            send_op(OP_WRITE_A, 0, 0, 32'h7FFF_FFFF);
            send_op(OP_WRITE_A, 0, 1, 32'h7FFF_FFFF);
            send_op(OP_WRITE_A, 1, 0, 32'h8000_0000);
            send_op(OP_WRITE_A, 1, 1, 32'h0000_0000);
            send_op(OP_WRITE_B, 0, 0, 32'h7FFF_FFFF);
            send_op(OP_WRITE_B, 1, 0, 32'h7FFF_FFFF);
            send_op(OP_WRITE_B, 0, 1, 32'h8000_0000);
            send_op(OP_WRITE_B, 1, 1, 32'h8000_0000);
            // out-of-range loads and the unused opcode must not disturb the stores
            send_op(OP_WRITE_A, 2, 0, 32'hDEAD_BEEF);
            send_op(OP_WRITE_A, 0, 31, 32'hDEAD_BEEF);
            send_op(OP_WRITE_B, 31, 1, 32'hDEAD_BEEF);
            send_op(OP_WRITE_B, 0, 2, 32'hDEAD_BEEF);
            send_op(OP_NONE, 31, 31, 32'hFFFF_FFFF);
            send_op(OP_COMPUTE, 0, 0, 32'h0);
            send_op(OP_COMPUTE, 31, 1, 32'hFFFF_FFFF);
            send_op(OP_COMPUTE, 0, 2, 32'h0);
            send_op(OP_COMPUTE, 0, 31, 32'h0);
            drain_all();
            // exactly the most negative value, no clipping
            send_op(OP_WRITE_A, 1, 0, 32'h8000_0000);
            send_op(OP_WRITE_B, 0, 0, 32'h0001_0000);
            send_op(OP_WRITE_B, 1, 0, 32'h0000_0000);
            send_op(OP_COMPUTE, 0, 0, 32'h0);
        end
    endtask

    // sizes written as zero and as the top code clamp to one and to the cap
    task automatic test_size_extremes();
        begin
            set_sizes(6'd0, 6'd0, 6'd0);
            fill_missing(-1);
            send_op(OP_COMPUTE, 0, 0, 32'h0);
            send_op(OP_COMPUTE, 0, 1, 32'h0);
            set_sizes(6'd63, 6'd1, 6'd63);
            fill_missing(31);
            send_op(OP_COMPUTE, 0, 31, 32'h0);
            set_sizes(6'd1, 6'd32, 6'd33);
            fill_missing(31);
            send_op(OP_COMPUTE, 0, 31, 32'h0);
        end
    endtask

    // hold the receiver off so the command queue fills and input stalls
    task automatic test_backpressure();
        int i;
        begin
            set_sizes(6'd4, 6'd4, 6'd4);
            fill_missing(-1);
            hold_cycles = 400;
            for (i = 0; i < 10; i++) send_op(OP_COMPUTE, 0, $urandom_range(0, 4), 32'h0);
        end
    endtask

    // random phases: sizes, loads with noise, then computes
    task automatic test_random_phases();
        int start, n, i, nr, nk, nc, c;
        logic [5:0] sr, sk, sc;
        t_opcode op;
        begin
            start = words_sent;
            while (words_sent - start < 100) begin
                if ($urandom_range(0, 4) == 0) begin
                    // clamped codes; inner length kept short so fills stay small
                    sr = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(33, 63));
                    sk = 6'($urandom_range(0, 2));
                    sc = 6'($urandom_range(0, 63));
                end else begin
                    sr = 6'($urandom_range(1, 6)); sk = 6'($urandom_range(1, 6));
                    sc = 6'($urandom_range(1, 6));
                end
                set_sizes(sr, sk, sc);
                nr = eff_dim(sr); nk = eff_dim(sk); nc = eff_dim(sc);
                n = $urandom_range(2, 12);
                for (i = 0; i < n; i++) begin
                    op = ($urandom_range(0, 1) == 0) ? OP_WRITE_A : OP_WRITE_B;
                    case ($urandom_range(0, 9))
                        0: send_op(OP_NONE, $urandom_range(0, 31), $urandom_range(0, 31),
                                   $urandom);
                        1, 2: send_op(op, $urandom_range(0, 31), $urandom_range(0, 31),
                                      rand_elem());
                        default: begin
                            if (op == OP_WRITE_A)
                                send_op(op, $urandom_range(0, nr-1), $urandom_range(0, nk-1),
                                        rand_elem());
                            else
                                send_op(op, $urandom_range(0, nk-1), $urandom_range(0, nc-1),
                                        rand_elem());
                        end
                    endcase
                end
                fill_missing(-1);
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++) begin
                    c = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31)
                                                    : $urandom_range(0, nc-1);
                    send_op(OP_COMPUTE, $urandom_range(0, 31), c, $urandom);
                end
            end
        end
    endtask

    initial begin
        int i;
        for (i = 0; i < DIM*DIM; i++) begin
            a_elems[i] = '0; b_elems[i] = '0;
            a_loaded[i] = 1'b0; b_loaded[i] = 1'b0;
        end
        rows_reg = 6'd32; inner_reg = 6'd32; cols_reg = 6'd32;
        fail_count = 0; words_sent = 0; results_seen = 0;
        compute_words = 0; sat_seen = 0; burst_left = 0; hold_cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = REG_ROWS_A; i_cfg_data = '0;
        in_ch.valid = 1'b0; in_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_values();
        test_size_extremes();
        test_backpressure();
        test_random_phases();

        drain_all();
        $display("covered %0d input words, %0d compute words, %0d result words",
                 words_sent, compute_words, results_seen);
        $display("clipped results: %0d, size settings included clamped extremes", sat_seen);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
